### design/sit_pkg.sv
// Shared constants and types for the segment intersection test.
package sit_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 4;
   localparam int DIFF_BITS  = COORD_BITS + 1;            // endpoint differences
   localparam int PROD_BITS  = 2 * DIFF_BITS + 1;         // signed cross products
   localparam int MAG_BITS   = PROD_BITS - 1;             // normalized d and t
   localparam int NUM_BITS   = MAG_BITS + COORD_BITS + FRAC_BITS; // dividend
   localparam int QUO_BITS   = COORD_BITS + FRAC_BITS;    // quotient and output
   localparam int IN_BITS    = 8 * COORD_BITS;
   localparam int IN_BYTES   = (IN_BITS + 7) / 8;
   localparam int OUT_BITS   = 2 * QUO_BITS;
   localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Front-to-back item: classification, start point and dividends.
   typedef struct packed {
      logic                         hit;
      logic                         parallel;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic                         neg_x;
      logic                         neg_y;
      logic [MAG_BITS-1:0]          d;
      logic [NUM_BITS-1:0]          num_x;
      logic [NUM_BITS-1:0]          num_y;
   } work_type;

endpackage

### design/sit_front.sv
// Front pipeline: differences, cross products, sign normalization, dividends.
module sit_front import sit_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [IN_BITS-1:0]    in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output work_type              out_item
);

   logic en;

   // stage 1
   logic                         v1_ff;
   logic signed [COORD_BITS-1:0] px1_ff, py1_ff;
   logic signed [DIFF_BITS-1:0]  rx1_ff, ry1_ff, vx1_ff, vy1_ff, dx1_ff, dy1_ff;
   // stage 2
   logic                         v2_ff;
   logic signed [COORD_BITS-1:0] px2_ff, py2_ff;
   logic signed [DIFF_BITS-1:0]  rx2_ff, ry2_ff;
   logic signed [PROD_BITS-1:0]  d2_ff, t2_ff, u2_ff;
   // stage 3
   logic                         v3_ff, hit3_ff, par3_ff, negx3_ff, negy3_ff;
   logic signed [COORD_BITS-1:0] px3_ff, py3_ff;
   logic [COORD_BITS-1:0]        ax3_ff, ay3_ff;
   logic [MAG_BITS-1:0]          d3_ff, t3_ff;
   // stage 4
   logic                         v4_ff;
   work_type                     item4_ff;

   logic signed [COORD_BITS-1:0] f_psx, f_psy, f_pex, f_pey, f_qsx, f_qsy, f_qex, f_qey;
   logic signed [PROD_BITS-1:0]  d_in, t_in, u_in, dn, tn, un;
   logic signed [DIFF_BITS-1:0]  rx_abs, ry_abs;
   logic                         neg_d;
   logic [MAG_BITS+COORD_BITS-1:0] prod_x, prod_y;

   assign en        = !v4_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = v4_ff;
   assign out_item  = item4_ff;

   assign f_psx = in_data[0*COORD_BITS +: COORD_BITS];
   assign f_psy = in_data[1*COORD_BITS +: COORD_BITS];
   assign f_pex = in_data[2*COORD_BITS +: COORD_BITS];
   assign f_pey = in_data[3*COORD_BITS +: COORD_BITS];
   assign f_qsx = in_data[4*COORD_BITS +: COORD_BITS];
   assign f_qsy = in_data[5*COORD_BITS +: COORD_BITS];
   assign f_qex = in_data[6*COORD_BITS +: COORD_BITS];
   assign f_qey = in_data[7*COORD_BITS +: COORD_BITS];

   assign d_in = PROD_BITS'(rx1_ff) * PROD_BITS'(vy1_ff) - PROD_BITS'(ry1_ff) * PROD_BITS'(vx1_ff);
   assign t_in = PROD_BITS'(dx1_ff) * PROD_BITS'(vy1_ff) - PROD_BITS'(dy1_ff) * PROD_BITS'(vx1_ff);
   assign u_in = PROD_BITS'(dx1_ff) * PROD_BITS'(ry1_ff) - PROD_BITS'(dy1_ff) * PROD_BITS'(rx1_ff);

   // flip signs together so that d is positive
   assign neg_d  = d2_ff[PROD_BITS-1];
   assign dn     = neg_d ? -d2_ff : d2_ff;
   assign tn     = neg_d ? -t2_ff : t2_ff;
   assign un     = neg_d ? -u2_ff : u2_ff;
   assign rx_abs = rx2_ff[DIFF_BITS-1] ? -rx2_ff : rx2_ff;
   assign ry_abs = ry2_ff[DIFF_BITS-1] ? -ry2_ff : ry2_ff;

   assign prod_x = t3_ff * ax3_ff;
   assign prod_y = t3_ff * ay3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff <= f_psx;
         py1_ff <= f_psy;
         rx1_ff <= DIFF_BITS'(f_pex) - DIFF_BITS'(f_psx);
         ry1_ff <= DIFF_BITS'(f_pey) - DIFF_BITS'(f_psy);
         vx1_ff <= DIFF_BITS'(f_qex) - DIFF_BITS'(f_qsx);
         vy1_ff <= DIFF_BITS'(f_qey) - DIFF_BITS'(f_qsy);
         dx1_ff <= DIFF_BITS'(f_qsx) - DIFF_BITS'(f_psx);
         dy1_ff <= DIFF_BITS'(f_qsy) - DIFF_BITS'(f_psy);

         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         rx2_ff <= rx1_ff;
         ry2_ff <= ry1_ff;
         d2_ff  <= d_in;
         t2_ff  <= t_in;
         u2_ff  <= u_in;

         par3_ff  <= (d2_ff == '0);
         hit3_ff  <= (d2_ff != '0) && !tn[PROD_BITS-1] && !un[PROD_BITS-1]
                     && (tn <= dn) && (un <= dn);
         px3_ff   <= px2_ff;
         py3_ff   <= py2_ff;
         negx3_ff <= rx2_ff[DIFF_BITS-1];
         negy3_ff <= ry2_ff[DIFF_BITS-1];
         ax3_ff   <= rx_abs[COORD_BITS-1:0];
         ay3_ff   <= ry_abs[COORD_BITS-1:0];
         d3_ff    <= dn[MAG_BITS-1:0];
         t3_ff    <= tn[MAG_BITS-1:0];

         item4_ff.hit      <= hit3_ff;
         item4_ff.parallel <= par3_ff;
         item4_ff.px       <= px3_ff;
         item4_ff.py       <= py3_ff;
         item4_ff.neg_x    <= negx3_ff;
         item4_ff.neg_y    <= negy3_ff;
         // keep a nonzero divisor for items that do not hit
         item4_ff.d        <= hit3_ff ? d3_ff : MAG_BITS'(1);
         item4_ff.num_x    <= hit3_ff ? (NUM_BITS'(prod_x) << FRAC_BITS) : '0;
         item4_ff.num_y    <= hit3_ff ? (NUM_BITS'(prod_y) << FRAC_BITS) : '0;
      end
   end

endmodule

### design/sit_queue.sv
// Short FIFO between the front and back pipelines.
module sit_queue import sit_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_item
);

   work_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, rd_ff;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_item;
   end

endmodule

### design/sit_back.sv
// Back pipeline: one quotient bit per stage, floor fix-up, output register.
module sit_back import sit_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  work_type              in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_hit,
   output logic                  out_parallel,
   output logic [QUO_BITS-1:0]   out_cross_x,
   output logic [QUO_BITS-1:0]   out_cross_y
);

   typedef struct packed {
      logic                         hit;
      logic                         parallel;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic                         neg_x;
      logic                         neg_y;
      logic [MAG_BITS-1:0]          d;
      logic [NUM_BITS-1:0]          rem_x;
      logic [NUM_BITS-1:0]          rem_y;
      logic [QUO_BITS-1:0]          q_x;
      logic [QUO_BITS-1:0]          q_y;
   } div_type;

   logic    en;
   logic    valid_ff [QUO_BITS+1];
   div_type stage_ff [QUO_BITS+1];
   div_type stage_in [QUO_BITS+1];
   logic    ov_ff, hit_ff, par_ff;
   logic [QUO_BITS-1:0] cx_ff, cy_ff;
   logic signed [QUO_BITS:0] off_x, off_y;
   logic signed [QUO_BITS-1:0] base_x, base_y;
   div_type last;

   // trial subtract of d shifted to the current quotient bit
   function automatic logic [NUM_BITS:0] trial(input logic [NUM_BITS-1:0] rem,
                                               input logic [MAG_BITS-1:0] d,
                                               input int sh);
      logic [NUM_BITS:0] dsh;
      dsh = (NUM_BITS+1)'(d) << sh;
      return {1'b0, rem} - dsh;
   endfunction

   always_comb begin
      logic [NUM_BITS:0] tx, ty;
      stage_in[0].hit      = in_item.hit;
      stage_in[0].parallel = in_item.parallel;
      stage_in[0].px       = in_item.px;
      stage_in[0].py       = in_item.py;
      stage_in[0].neg_x    = in_item.neg_x;
      stage_in[0].neg_y    = in_item.neg_y;
      stage_in[0].d        = in_item.d;
      stage_in[0].rem_x    = in_item.num_x;
      stage_in[0].rem_y    = in_item.num_y;
      stage_in[0].q_x      = '0;
      stage_in[0].q_y      = '0;
      for (int k = 0; k < QUO_BITS; k++) begin
         tx = trial(stage_ff[k].rem_x, stage_ff[k].d, QUO_BITS - 1 - k);
         ty = trial(stage_ff[k].rem_y, stage_ff[k].d, QUO_BITS - 1 - k);
         stage_in[k+1] = stage_ff[k];
         stage_in[k+1].q_x = {stage_ff[k].q_x[QUO_BITS-2:0], !tx[NUM_BITS]};
         stage_in[k+1].q_y = {stage_ff[k].q_y[QUO_BITS-2:0], !ty[NUM_BITS]};
         if (!tx[NUM_BITS]) stage_in[k+1].rem_x = tx[NUM_BITS-1:0];
         if (!ty[NUM_BITS]) stage_in[k+1].rem_y = ty[NUM_BITS-1:0];
      end
   end

   assign en       = !ov_ff || out_ready;
   assign in_ready = en;
   assign last     = stage_ff[QUO_BITS];

   // round toward minus infinity for a negative direction
   assign off_x = last.neg_x ? -((QUO_BITS+1)'(last.q_x) + (QUO_BITS+1)'(last.rem_x != '0))
                             : (QUO_BITS+1)'(last.q_x);
   assign off_y = last.neg_y ? -((QUO_BITS+1)'(last.q_y) + (QUO_BITS+1)'(last.rem_y != '0))
                             : (QUO_BITS+1)'(last.q_y);
   assign base_x = QUO_BITS'(last.px) <<< FRAC_BITS;
   assign base_y = QUO_BITS'(last.py) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_BITS; k++) valid_ff[k] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < QUO_BITS; k++) valid_ff[k+1] <= valid_ff[k];
         ov_ff <= valid_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QUO_BITS; k++) stage_ff[k] <= stage_in[k];
         hit_ff <= last.hit;
         par_ff <= last.parallel;
         cx_ff  <= last.hit ? QUO_BITS'(base_x + QUO_BITS'(off_x)) : '0;
         cy_ff  <= last.hit ? QUO_BITS'(base_y + QUO_BITS'(off_y)) : '0;
      end
   end

   assign out_valid    = ov_ff;
   assign out_hit      = hit_ff;
   assign out_parallel = par_ff;
   assign out_cross_x  = cx_ff;
   assign out_cross_y  = cy_ff;

endmodule

### design/segment_intersection_test.sv
// Top level of the segment intersection test.
//
// Input channel req_*: one item per handshake holding two segments as eight
// signed endpoint coordinates. Result channel rsp_*: one item per input with
// hit and parallel flags in tuser and the floored crossing point (Q.4) in
// tdata; the point is zero when there is no hit.
// Throughput: one item per cycle when nothing stalls. The path runs through 4 front
// stages, the queue, a load stage plus 20 divider stages (one quotient bit each) and the
// output register. The front and the back each stall on their own; a four-entry queue
// sits between them. When rsp_tready is low, the result holds in the output register,
// the back pipeline freezes, the queue fills and then req_tready drops. Reset empties
// every stage and the queue; items in flight are lost.
module segment_intersection_test import sit_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  logic [8*IN_BYTES-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // cross_x, cross_y
   output logic [8*OUT_BYTES-1:0] rsp_tdata,
   // hit, parallel
   output logic [1:0]             rsp_tuser
);

   logic          fq_valid, fq_ready, qb_valid, qb_ready;
   work_type      fq_item, qb_item;
   logic          b_hit, b_par;
   logic [QUO_BITS-1:0] b_cx, b_cy;

   sit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata[IN_BITS-1:0]),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   sit_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   sit_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (qb_valid),
      .in_ready     (qb_ready),
      .in_item      (qb_item),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_hit      (b_hit),
      .out_parallel (b_par),
      .out_cross_x  (b_cx),
      .out_cross_y  (b_cy)
   );

   assign rsp_tuser = {b_par, b_hit};
   assign rsp_tdata = (8*OUT_BYTES)'({b_cy, b_cx});

endmodule
